// ===== hw/rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants for the positional list engine
// Slot store geometry, request and status codes, queue entry layout.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int Capacity = 64;
  localparam int SlotW    = $clog2(Capacity);
  localparam int CountW   = $clog2(Capacity + 1);
  localparam int PosW     = 7;
  localparam int OpW      = 3;
  localparam int StW      = 3;

  typedef enum logic [OpW-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_REMOVE   = 3'd3,
    OP_SEARCH   = 3'd4
  } op_t;

  typedef enum logic [StW-1:0] {
    ST_OK      = 3'd0,
    ST_BAD_POS = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_MISS    = 3'd4
  } status_t;

  // One queued request: raw fields, classified by the back end.
  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [31:0]     value;
    logic [PosW-1:0] position;
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WAIT,
    S_STEP,
    S_FIX,
    S_OUT
  } state_t;

endpackage

// ===== hw/rtl/positional_list_engine_top.sv =====
// Rejected requests go straight to the result; head/tail inserts skip the
//   walk, while middle inserts, removes and searches walk link by link.
// The list executor takes one item at a time; a two-entry queue in front
//   accepts beats meanwhile.
// Reset: rst synchronous, empties the list and frees every slot.
// ----------------------------------------------------------------------------
// positional_list_engine_top: doubly linked list engine
// Request queue feeding a link-walking executor with a registered result.
// ----------------------------------------------------------------------------
module positional_list_engine_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ple_pkg::OpW-1:0]  op,
  input  logic signed [31:0]       value,
  input  logic [ple_pkg::PosW-1:0] position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ple_pkg::StW-1:0]  status,
  output logic [ple_pkg::PosW-1:0] found_position,
  output logic signed [31:0]       removed_value,
  output logic [ple_pkg::PosW-1:0] entry_count
);
  import ple_pkg::*;

  req_t in_req, q_req;
  logic q_valid, q_take;

  assign in_req = '{op: op, value: value, position: position};

  ple_queue u_queue (
    .clk, .rst,
    .in_valid, .in_stall, .in_req,
    .out_valid(q_valid), .out_take(q_take), .out_req(q_req)
  );

  ple_back u_back (
    .clk, .rst,
    .req_valid(q_valid), .req_take(q_take), .req(q_req),
    .res_valid(out_valid), .res_stall(out_stall),
    .status, .found_position, .removed_value, .entry_count
  );
endmodule

// ===== hw/rtl/ple_queue.sv =====
// ----------------------------------------------------------------------------
// ple_queue: two-entry request queue between front and back end
// Registers incoming beats so the front waits on list walks only when both entries are full.
// ----------------------------------------------------------------------------
module ple_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ple_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_take,
  output ple_pkg::req_t out_req
);
  import ple_pkg::*;

  req_t mem [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] fill;
  logic push, pop;

  assign in_stall  = (fill == 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_req   = mem[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && out_take;

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_req;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== hw/rtl/ple_back.sv =====
// ----------------------------------------------------------------------------
// ple_back: list executor
// Walks the linked slot store one link per step and applies each request.
// ----------------------------------------------------------------------------
module ple_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_take,
  input  ple_pkg::req_t                 req,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [ple_pkg::StW-1:0]       status,
  output logic [ple_pkg::PosW-1:0]      found_position,
  output logic signed [31:0]            removed_value,
  output logic [ple_pkg::PosW-1:0]      entry_count
);
  import ple_pkg::*;

  // slot store, undefined until written
  logic [31:0]      val_mem  [Capacity];
  logic [SlotW-1:0] next_mem [Capacity];
  logic [SlotW-1:0] prev_mem [Capacity];

  logic [SlotW-1:0]  head_slot, tail_slot;
  logic [CountW-1:0] item_count;
  logic [Capacity-1:0] free_map;

  state_t state, state_next;
  req_t   cur;
  logic [SlotW-1:0]  cur_slot;     // slot being visited
  logic [CountW-1:0] step;         // 1-based position of cur_slot
  logic [CountW-1:0] target;       // walk goal
  logic [SlotW-1:0]  new_slot;
  logic [31:0]       rd_val;
  logic [SlotW-1:0]  rd_next, rd_prev;
  logic              fix_phase;

  // second link write of a middle insert, held from the first fix cycle
  logic             walk_mid;
  logic [SlotW-1:0] mid_after;

  // lowest free slot (priority encoder)
  logic [SlotW-1:0] free_slot;
  logic             any_free;
  always_comb begin
    free_slot = '0;
    any_free  = 1'b0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        free_slot = SlotW'(i);
        any_free  = 1'b1;
      end
    end
  end

  // request classification
  logic [CountW:0] pos_w, cnt_w;
  logic            ins_op, pos_ok_ins, pos_ok_rem, walk_ins;
  status_t         early_st;
  logic            early;
  always_comb begin
    pos_w  = (CountW+1)'(req.position);
    cnt_w  = (CountW+1)'(item_count);
    ins_op = (req.op == OP_INS_HEAD) || (req.op == OP_INS_TAIL) ||
             (req.op == OP_INS_POS);
    pos_ok_ins = (pos_w != '0) && (pos_w <= cnt_w + 1'b1);
    pos_ok_rem = (pos_w != '0) && (pos_w <= cnt_w);
    early    = 1'b0;
    early_st = ST_OK;
    unique case (req.op)
      OP_INS_HEAD, OP_INS_TAIL: begin
        if (!any_free) begin early = 1'b1; early_st = ST_FULL; end
      end
      OP_INS_POS: begin
        if (!pos_ok_ins)    begin early = 1'b1; early_st = ST_BAD_POS; end
        else if (!any_free) begin early = 1'b1; early_st = ST_FULL; end
      end
      OP_REMOVE: begin
        if (item_count == '0) begin early = 1'b1; early_st = ST_EMPTY; end
        else if (!pos_ok_rem) begin early = 1'b1; early_st = ST_BAD_POS; end
      end
      OP_SEARCH: begin
        if (item_count == '0) begin early = 1'b1; early_st = ST_MISS; end
      end
      default: begin early = 1'b1; early_st = ST_BAD_POS; end
    endcase
    // positional insert in the middle needs a walk to the slot before it
    walk_ins = (req.op == OP_INS_POS) && (pos_w > 1) && (pos_w <= cnt_w);
  end

  assign req_take  = (state == S_IDLE) && req_valid;
  assign res_valid = (state == S_OUT);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_valid) begin
        if (early) state_next = S_OUT;
        else if (ins_op && !walk_ins) state_next = S_FIX;
        else state_next = S_RD;
      end
      S_RD:   state_next = S_WAIT;
      S_WAIT: state_next = S_STEP;
      S_STEP: begin
        if (cur.op == OP_SEARCH[OpW-1:0]) begin
          if (rd_val == cur.value) state_next = S_OUT;
          else if (step == item_count) state_next = S_OUT;
          else state_next = S_RD;
        end else if (step == target) state_next = S_FIX;
        else state_next = S_RD;
      end
      S_FIX:  if (fix_phase) state_next = S_OUT;
      S_OUT:  if (!res_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // registered reads of the slot store
  always_ff @(posedge clk) begin
    rd_val  <= val_mem[cur_slot];
    rd_next <= next_mem[cur_slot];
    rd_prev <= prev_mem[cur_slot];
  end

  // control, link updates and result
  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot  <= '0;
      tail_slot  <= '0;
      item_count <= '0;
      free_map   <= '1;
      fix_phase  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (req_valid) begin
          cur            <= req;
          cur_slot       <= head_slot;
          step           <= CountW'(1);
          new_slot       <= free_slot;
          fix_phase      <= 1'b0;
          status         <= early_st;
          found_position <= '0;
          removed_value  <= '0;
          entry_count    <= PosW'(item_count);
          target         <= walk_ins ? CountW'(req.position - 1'b1)
                                     : CountW'(req.position);
        end
        S_STEP: begin
          if (cur.op == OP_SEARCH[OpW-1:0]) begin
            if (rd_val == cur.value) found_position <= PosW'(step);
            else if (step == item_count) status <= ST_MISS;
          end
          if (!(step == target && cur.op != OP_SEARCH[OpW-1:0])) begin
            cur_slot <= rd_next;
            step     <= step + 1'b1;
          end
        end
        S_FIX: begin
          fix_phase <= 1'b1;
          if (cur.op == OP_REMOVE[OpW-1:0]) begin
            if (!fix_phase) begin
              removed_value <= rd_val;
              free_map[cur_slot] <= 1'b1;
              item_count  <= item_count - 1'b1;
              entry_count <= PosW'(item_count - 1'b1);
              if (item_count == CountW'(1)) begin
                head_slot <= '0;
                tail_slot <= '0;
              end else if (target == CountW'(1)) begin
                head_slot <= rd_next;
                prev_mem[rd_next] <= '0;
              end else if (target == item_count) begin
                tail_slot <= rd_prev;
                next_mem[rd_prev] <= '0;
              end else begin
                next_mem[rd_prev] <= rd_next;
                prev_mem[rd_next] <= rd_prev;
              end
            end
          end else if (!fix_phase) begin
            free_map[new_slot] <= 1'b0;
            val_mem[new_slot]  <= cur.value;
            item_count  <= item_count + 1'b1;
            entry_count <= PosW'(item_count + 1'b1);
            if (item_count == '0) begin
              head_slot <= new_slot; tail_slot <= new_slot;
              next_mem[new_slot] <= '0; prev_mem[new_slot] <= '0;
            end else if (cur.op == OP_INS_HEAD[OpW-1:0] ||
                         (cur.op == OP_INS_POS[OpW-1:0] &&
                          cur.position == PosW'(1))) begin
              next_mem[new_slot]  <= head_slot;
              prev_mem[new_slot]  <= '0;
              prev_mem[head_slot] <= new_slot;
              head_slot <= new_slot;
            end else if (cur.op == OP_INS_TAIL[OpW-1:0] ||
                         CountW'(cur.position) > item_count) begin
              prev_mem[new_slot]  <= tail_slot;
              next_mem[new_slot]  <= '0;
              next_mem[tail_slot] <= new_slot;
              tail_slot <= new_slot;
            end else begin
              // cur_slot is the slot before, rd_next the slot after
              next_mem[new_slot] <= rd_next;
              prev_mem[new_slot] <= cur_slot;
              next_mem[cur_slot] <= new_slot;
            end
          end else if (walk_mid) begin
            prev_mem[mid_after] <= new_slot;
          end
        end
        default: ;
      endcase
    end
  end

  // capture the slot after a middle insert for the second fix cycle
  always_ff @(posedge clk) begin
    if (state == S_FIX && !fix_phase) begin
      walk_mid  <= (cur.op == OP_INS_POS[OpW-1:0]) && (item_count != '0) &&
                   (cur.position > PosW'(1)) &&
                   (CountW'(cur.position) <= item_count);
      mid_after <= rd_next;
    end
  end
endmodule

// ===== verif/positional_list_engine_top_test.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_top_test: self-checking bench for the list engine
// Queue-fed driver and clocked monitor; a behavioural list model predicts
// status, found position, removed value and count for every request beat.
// ----------------------------------------------------------------------------
module positional_list_engine_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ple_pkg::*;

  // undefined request codes
  localparam logic [OpW-1:0] OP_RSVD_A = 3'd5;
  localparam logic [OpW-1:0] OP_RSVD_B = 3'd6;
  localparam logic [OpW-1:0] OP_RSVD_C = 3'd7;

  typedef struct {
    logic [OpW-1:0]    op;
    logic [31:0]       value;
    logic [PosW-1:0]   position;
  } req_beat_t;

  typedef struct {
    logic [StW-1:0]  status;
    logic [PosW-1:0] found;
    logic [31:0]     removed;
    logic [PosW-1:0] count;
  } rsp_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OpW-1:0] op = '0;
  logic signed [31:0] value = '0;
  logic [PosW-1:0] position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [StW-1:0] status;
  logic [PosW-1:0] found_position;
  logic signed [31:0] removed_value;
  logic [PosW-1:0] entry_count;

  positional_list_engine_top u_dut (
    .clk, .rst, .in_valid, .in_stall, .op, .value, .position,
    .out_valid, .out_stall, .status, .found_position, .removed_value,
    .entry_count
  );

  always #1 clk = ~clk;

  req_beat_t pending_reqs[$];
  rsp_beat_t expected_rsps[$];
  // List contents in order; slot layout is invisible at the ports.
  logic [31:0] list_vals[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int hold_off = 0;      // long receiver stall, cycles left
  bit pause_tx = 1'b0;   // sender drained-wait request
  int tx_gap = 0;
  int rx_gap = 0;

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // Behavioural list model
  function automatic rsp_beat_t predict_list(req_beat_t r);
    rsp_beat_t e;
    int n;
    n = list_vals.size();
    e.status = ST_OK; e.found = '0; e.removed = '0;
    case (r.op)
      OP_INS_HEAD: if (n >= Capacity) e.status = ST_FULL; else list_vals.push_front(r.value);
      OP_INS_TAIL: if (n >= Capacity) e.status = ST_FULL; else list_vals.push_back(r.value);
      OP_INS_POS: begin
        if (r.position < 1 || r.position > n + 1) e.status = ST_BAD_POS;
        else if (n >= Capacity) e.status = ST_FULL;
        else list_vals.insert(r.position - 1, r.value);
      end
      OP_REMOVE: begin
        if (n == 0) e.status = ST_EMPTY;
        else if (r.position < 1 || r.position > n) e.status = ST_BAD_POS;
        else begin
          e.removed = list_vals[r.position - 1];
          list_vals.delete(r.position - 1);
        end
      end
      OP_SEARCH: begin
        e.status = ST_MISS;
        for (int i = 0; i < n; i++) begin
          if (list_vals[i] == r.value) begin
            e.status = ST_OK; e.found = PosW'(i + 1);
            break;
          end
        end
      end
      default: e.status = ST_BAD_POS;
    endcase
    e.count = PosW'(list_vals.size());
    return e;
  endfunction

  function automatic void add_req(logic [OpW-1:0] o, logic [31:0] v, logic [PosW-1:0] p);
    req_beat_t r;
    r.op = o; r.value = v; r.position = p;
    pending_reqs.push_back(r);
  endfunction

  // Driver: one nonblocking write per signal per edge
  always @(posedge clk) begin
    req_beat_t r;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_rsps.push_back(predict_list(pending_reqs[0]));
        pending_reqs.pop_front();
        n_sent++;
        tx_gap = gap_len();
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && !pause_tx && tx_gap == 0) begin
          r = pending_reqs[0];
          in_valid <= 1'b1; op <= r.op; value <= r.value; position <= r.position;
        end else begin
          in_valid <= 1'b0;
          if (tx_gap > 0) tx_gap--;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    rsp_beat_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          n_checked++;
          if (status !== e.status) begin
            $error("status exp %0d got %0d", e.status, status); errors++;
          end
          if (found_position !== e.found) begin
            $error("found_position exp %0d got %0d", e.found, found_position); errors++;
          end
          if (removed_value !== e.removed) begin
            $error("removed_value exp %0d got %0d", $signed(e.removed), removed_value);
            errors++;
          end
          if (entry_count !== e.count) begin
            $error("entry_count exp %0d got %0d", e.count, entry_count); errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        rx_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int sz;
    int pos;
    logic [2:0] o;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // Directed: empty-list cases, extremes, undefined ops
    add_req(OP_REMOVE, 32'd0, 7'd1);
    add_req(OP_SEARCH, 32'd5, 7'd0);
    add_req(OP_INS_POS, 32'd1, 7'd0);
    add_req(OP_INS_POS, 32'd1, 7'd2);
    add_req(OP_INS_HEAD, 32'h8000_0000, 7'd0);
    add_req(OP_INS_TAIL, 32'h7FFF_FFFF, 7'd127);
    add_req(OP_INS_POS, 32'hFFFF_FFFF, 7'd2);
    add_req(OP_INS_POS, 32'd0, 7'd4);
    add_req(OP_SEARCH, 32'h7FFF_FFFF, 7'd0);
    add_req(OP_SEARCH, 32'd12345, 7'd0);
    add_req(OP_REMOVE, 32'd0, 7'd0);
    add_req(OP_REMOVE, 32'd0, 7'd5);
    add_req(OP_REMOVE, 32'd0, 7'd2);
    add_req(OP_RSVD_A, 32'd1, 7'd1);
    add_req(OP_RSVD_B, 32'd1, 7'd1);
    add_req(OP_RSVD_C, 32'd1, 7'd1);
    add_req(OP_REMOVE, 32'd0, 7'd3);
    add_req(OP_REMOVE, 32'd0, 7'd1);
    add_req(OP_REMOVE, 32'd0, 7'd1);
    add_req(OP_REMOVE, 32'd0, 7'd1);
    // Random: fill towards full, then drain, tracking size roughly
    sz = 0;
    for (int i = 0; i < 1800; i++) begin
      pos = 0;
      if (i == 300) begin
        // long receiver stall while the sender keeps offering
        while (pending_reqs.size() > 0) @(posedge clk);
        hold_off = 300;
      end
      if (i == 900) begin
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
        pause_tx = 1'b1;
        repeat (50) @(posedge clk);
        pause_tx = 1'b0;
      end
      o = ((i / 200) % 2 == 0) ? 3'($urandom_range(0, 4))
          : (($urandom_range(0, 1) != 0) ? OP_REMOVE : 3'($urandom_range(0, 4)));
      if ($urandom_range(0, 40) == 0) o = 3'($urandom_range(5, 7));
      pos = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127) : $urandom_range(1, sz + 1);
      add_req(o, ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 7)) : $urandom(),
              PosW'(pos));
      if (o <= OP_INS_POS && sz < Capacity) sz++;
      else if (o == OP_REMOVE && sz > 0) sz--;
    end
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
    repeat (250) @(posedge clk);
    $display("sent %0d requests, checked %0d results; list filled, drained, stalled",
             n_sent, n_checked);
    if (errors == 0 && expected_rsps.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
